/* src/sscq_pkg.sv */
// Shared types, constants and helpers of the segment store collision query.
// Used by the modules sscq_front, sscq_fifo, sscq_back and the top level.
package sscq_pkg;

	localparam int COORD_W = 24;
	localparam int DIFF_W  = 25;
	localparam int SLOT_W  = 12;
	localparam int RAD_W   = 23;
	localparam int R2_W    = 46;
	localparam int COUNT_W = 13;

	// command codes on the request channel
	typedef enum logic [1:0] {
		CMD_WRITE  = 2'd0,
		CMD_CIRCLE = 2'd1,
		CMD_RAY    = 2'd2,
		CMD_NONE   = 2'd3
	} cmd_t;

	// work kinds after classification
	typedef enum logic [1:0] {
		OP_WRITE  = 2'd0,
		OP_CIRCLE = 2'd1,
		OP_RAY    = 2'd2
	} op_t;

	typedef logic signed [COORD_W-1:0] coord_t;
	typedef logic signed [DIFF_W-1:0]  diff_t;

	// one stored wall segment
	typedef struct packed {
		coord_t x0;
		coord_t y0;
		coord_t x1;
		coord_t y1;
	} seg_t;

	// one queue entry from the front to the back
	typedef struct packed {
		op_t               op;
		logic [SLOT_W-1:0] slot;
		coord_t            ax;
		coord_t            ay;
		coord_t            bx;
		coord_t            by;
		diff_t             rx;
		diff_t             ry;
		logic [R2_W-1:0]   r2;
	} qent_t;

	// queue status seen by the top level
	typedef struct packed {
		logic full;
		logic empty;
	} qstat_t;

	// exact difference of two coordinates
	function automatic diff_t diff24(input coord_t a, input coord_t b);
		return diff_t'({a[COORD_W-1], a}) - diff_t'({b[COORD_W-1], b});
	endfunction

endpackage

/* src/sscq_if.sv */
// Request and response channel interfaces of the segment store collision query.
// No dependencies.
interface sscq_req_if;
	logic               valid;
	logic               ready;
	logic [1:0]         cmd;
	logic [11:0]        slot;
	logic signed [23:0] start_x;
	logic signed [23:0] start_y;
	logic signed [23:0] end_x;
	logic signed [23:0] end_y;
	logic [22:0]        radius;

	modport source(output valid, cmd, slot, start_x, start_y, end_x, end_y, radius,
		input ready);
	modport sink(input valid, cmd, slot, start_x, start_y, end_x, end_y, radius,
		output ready);
endinterface

interface sscq_rsp_if;
	logic               valid;
	logic               ready;
	logic               hit;
	logic signed [23:0] hit_x;
	logic signed [23:0] hit_y;

	modport source(output valid, hit, hit_x, hit_y, input ready);
	modport sink(input valid, hit, hit_x, hit_y, output ready);
endinterface

/* src/segment_store_collision_query.sv */
// Top level of the segment store collision query: count register, front end,
// queue and back end. Depends on sscq_pkg, sscq_if, sscq_front, sscq_fifo, sscq_back.
//
//   channel  dir  handshake        payload
//   req      in   valid / ready    cmd, slot, start_x, start_y, end_x, end_y, radius
//   rsp      out  valid / ready    hit, hit_x, hit_y
//   cfg      in   cfg_we           cfg_wdata (segment_count)
//
// A write is taken while the back end is idle. A query passes an accept and a result
// step plus, per examined segment, a circle test (decided at an end point, or the
// interior test) or a ray test (no hit, or a hit with the 25-step rounding divide);
// the one shared 27x27 multiplier and the bit-serial divider serialize this work.
// A circle query stops at its first hit. The front accepts items while the back
// works, up to two queued entries plus one in the front stage; a waiting result
// stalls only the next query's end. Reset clears control, the count and the held result only.
module segment_store_collision_query #(
	parameter int MAX_SEGMENTS = 4096
) (
	input  logic        clk,
	input  logic        arst_n,
	sscq_req_if.sink    req,
	sscq_rsp_if.source  rsp,
	input  logic        cfg_we,
	input  logic [12:0] cfg_wdata
);
	import sscq_pkg::*;

	logic [COUNT_W-1:0] count_q;
	logic               f_valid, f_ready;
	qent_t              f_data;
	logic               b_valid, b_ready;
	qent_t              b_data;
	qstat_t             qstat;

	// hold the segment count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (cfg_we) begin
			count_q <= cfg_wdata;
		end
	end

	sscq_front #(.MAX_SEGMENTS(MAX_SEGMENTS)) u_front (
		.clk     (clk),
		.arst_n  (arst_n),
		.req     (req),
		.q_valid (f_valid),
		.q_data  (f_data),
		.q_ready (f_ready)
	);

	sscq_fifo u_fifo (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (f_valid),
		.push_ready (f_ready),
		.push_data  (f_data),
		.pop_valid  (b_valid),
		.pop_ready  (b_ready),
		.pop_data   (b_data),
		.stat       (qstat)
	);

	sscq_back #(.MAX_SEGMENTS(MAX_SEGMENTS)) u_back (
		.clk     (clk),
		.arst_n  (arst_n),
		.q_valid (b_valid),
		.q_ready (b_ready),
		.q_data  (b_data),
		.count   (count_q),
		.rsp     (rsp)
	);

	// queue never reports full and empty at once
	a_q_sane: assert property (@(posedge clk) disable iff (!arst_n)
		!(qstat.full && qstat.empty))
		else $error("queue full and empty together");

	// a push into a full queue would lose an item
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		(f_valid && f_ready) |-> !qstat.full)
		else $error("push into full queue");

	// a pop from an empty queue would invent an item
	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		(b_valid && b_ready) |-> !qstat.empty)
		else $error("pop from empty queue");

	// a result without a hit carries a zero point
	a_miss_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp.valid && !rsp.hit) |-> (rsp.hit_x == '0 && rsp.hit_y == '0))
		else $error("miss with nonzero point");

endmodule

/* src/sscq_front.sv */
// Front end: accepts request items, drops ones with no effect, and
// precomputes ray deltas and squared radius. Depends on sscq_pkg, sscq_if.
module sscq_front #(
	parameter int MAX_SEGMENTS = 4096
) (
	input  logic           clk,
	input  logic           arst_n,
	sscq_req_if.sink       req,
	output logic           q_valid,
	output sscq_pkg::qent_t q_data,
	input  logic           q_ready
);
	import sscq_pkg::*;

	localparam int CW  = $clog2(MAX_SEGMENTS + 1);
	localparam int SLW = (CW > SLOT_W) ? CW : SLOT_W;

	logic              valid_s1;
	logic [1:0]        cmd_s1;
	logic [SLOT_W-1:0] slot_s1;
	coord_t            ax_s1, ay_s1, bx_s1, by_s1;
	logic [RAD_W-1:0]  rad_s1;
	logic              keep_s1;
	logic              advance;
	op_t               op_s1;

	// classify the held item
	always_comb begin
		keep_s1 = 1'b0;
		op_s1   = OP_WRITE;
		case (cmd_s1)
			CMD_WRITE: begin
				keep_s1 = SLW'(slot_s1) < SLW'(MAX_SEGMENTS);
				op_s1   = OP_WRITE;
			end
			CMD_CIRCLE: begin
				keep_s1 = 1'b1;
				op_s1   = OP_CIRCLE;
			end
			CMD_RAY: begin
				keep_s1 = 1'b1;
				op_s1   = OP_RAY;
			end
			default: begin
				keep_s1 = 1'b0;
				op_s1   = OP_WRITE;
			end
		endcase
	end

	// build the queue entry
	always_comb begin
		q_data.op   = op_s1;
		q_data.slot = slot_s1;
		q_data.ax   = ax_s1;
		q_data.ay   = ay_s1;
		q_data.bx   = bx_s1;
		q_data.by   = by_s1;
		q_data.rx   = diff24(bx_s1, ax_s1);
		q_data.ry   = diff24(by_s1, ay_s1);
		q_data.r2   = R2_W'(rad_s1) * R2_W'(rad_s1);
	end

	assign q_valid   = valid_s1 && keep_s1;
	assign advance   = valid_s1 && (!keep_s1 || q_ready);
	assign req.ready = !valid_s1 || advance;

	// hold the stage valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (req.ready) begin
			valid_s1 <= req.valid;
		end
	end

	// capture the item
	always_ff @(posedge clk) begin
		if (req.valid && req.ready) begin
			cmd_s1  <= req.cmd;
			slot_s1 <= req.slot;
			ax_s1   <= req.start_x;
			ay_s1   <= req.start_y;
			bx_s1   <= req.end_x;
			by_s1   <= req.end_y;
			rad_s1  <= req.radius;
		end
	end

endmodule

/* src/sscq_fifo.sv */
// Two-entry queue between the front and the back end.
// Depends on sscq_pkg.
module sscq_fifo (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            push_valid,
	output logic            push_ready,
	input  sscq_pkg::qent_t push_data,
	output logic            pop_valid,
	input  logic            pop_ready,
	output sscq_pkg::qent_t pop_data,
	output sscq_pkg::qstat_t stat
);
	import sscq_pkg::*;

	qent_t      ent_q [2];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] cnt_q;
	logic       push;
	logic       pop;

	assign stat.full  = (cnt_q == 2'd2);
	assign stat.empty = (cnt_q == 2'd0);
	assign push_ready = !stat.full;
	assign pop_valid  = !stat.empty;
	assign pop_data   = ent_q[rd_ptr_q];
	assign push       = push_valid && push_ready;
	assign pop        = pop_valid && pop_ready;

	// advance pointers and count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			cnt_q    <= 2'd0;
		end else begin
			if (push) wr_ptr_q <= !wr_ptr_q;
			if (pop)  rd_ptr_q <= !rd_ptr_q;
			cnt_q <= cnt_q + {1'b0, push} - {1'b0, pop};
		end
	end

	// store entries
	always_ff @(posedge clk) begin
		if (push) ent_q[wr_ptr_q] <= push_data;
	end

endmodule

/* src/sscq_back.sv */
// Back end: segment memory and the per-segment circle and ray tests on one
// shared multiplier and a bit-serial rounding divider. Depends on sscq_pkg, sscq_if.
module sscq_back #(
	parameter int MAX_SEGMENTS = 4096
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          q_valid,
	output logic                          q_ready,
	input  sscq_pkg::qent_t               q_data,
	input  logic [sscq_pkg::COUNT_W-1:0]  count,
	sscq_rsp_if.source                    rsp
);
	import sscq_pkg::*;

	localparam int AW = $clog2(MAX_SEGMENTS);
	localparam int CW = $clog2(MAX_SEGMENTS + 1);
	localparam int NW = (CW > COUNT_W) ? CW : COUNT_W;

	typedef enum logic [5:0] {
		ST_IDLE, ST_RD, ST_LD,
		ST_C_LEN_X, ST_C_LEN_Y, ST_C_T_X, ST_C_T_Y, ST_C_V_X, ST_C_V_Y,
		ST_C_W_X, ST_C_W_Y, ST_C_CR_A, ST_C_CR_B, ST_C_DEC,
		ST_C_SQ_HH, ST_C_SQ_HL, ST_C_SQ_LL,
		ST_C_RL_HH, ST_C_RL_HL, ST_C_RL_LH, ST_C_RL_LL, ST_C_CMP,
		ST_R_NUM_A, ST_R_NUM_B, ST_R_DEN_A, ST_R_DEN_B, ST_R_NB_A, ST_R_NB_B, ST_R_DEC,
		ST_R_PX_L, ST_R_PX_H, ST_R_PY_L, ST_R_PY_H, ST_R_DIVI, ST_R_DIV,
		ST_R_DX, ST_R_DY, ST_R_UPD,
		ST_NEXT, ST_DONE
	} state_t;

	state_t state_q;

	seg_t mem [MAX_SEGMENTS];

	qent_t          cur_q;
	logic [CW-1:0]  idx_q, n_q;
	seg_t           seg_q;
	diff_t          dx_q, dy_q, vx_q, vy_q, wx_q, wy_q;
	logic [49:0]    len2_q, dv_q, dw_q, dist_q, best_q;
	logic signed [50:0] t_q, cr_q, num_q, den_q, nb_q;
	logic [99:0]    lhs_q, rhs_q;
	logic [75:0]    px_q, py_q;
	logic [51:0]    remx_q, remy_q;
	logic [24:0]    nshx_q, nshy_q, qx_q, qy_q;
	logic [4:0]     cnt_q;
	logic           hit_q;
	coord_t         hx_q, hy_q;
	logic           ovalid_q, ohit_q;
	coord_t         ohx_q, ohy_q;

	logic signed [26:0] ma, mb;
	logic signed [53:0] prod;
	logic [53:0]        pu;
	logic [NW-1:0]      cnt_ext, max_ext;
	logic [CW-1:0]      lim;
	logic [24:0]        rxm, rym;
	logic               c_end, c_far, c_dec_hit, c_wide_hit;
	logic signed [50:0] nn, dd, bb;
	logic               r_ok;
	logic [76:0]        nx, ny;
	logic [51:0]        dvs, trx, try_;
	logic               gex, gey;
	logic [24:0]        hx_sum, hy_sum;
	logic               seg_done_ok;

	function automatic logic signed [26:0] sx(input diff_t v);
		return {{2{v[DIFF_W-1]}}, v};
	endfunction

	// clamp the examined count to the store size
	assign cnt_ext = NW'(count);
	assign max_ext = NW'(MAX_SEGMENTS);
	assign lim     = CW'((cnt_ext > max_ext) ? max_ext : cnt_ext);

	assign rxm = cur_q.rx[DIFF_W-1] ? -cur_q.rx : cur_q.rx;
	assign rym = cur_q.ry[DIFF_W-1] ? -cur_q.ry : cur_q.ry;

	// select multiplier operands for the current step
	always_comb begin
		ma = '0;
		mb = '0;
		case (state_q)
			ST_C_LEN_X: begin ma = sx(dx_q); mb = sx(dx_q); end
			ST_C_LEN_Y: begin ma = sx(dy_q); mb = sx(dy_q); end
			ST_C_T_X:   begin ma = sx(dx_q); mb = sx(vx_q); end
			ST_C_T_Y:   begin ma = sx(dy_q); mb = sx(vy_q); end
			ST_C_V_X:   begin ma = sx(vx_q); mb = sx(vx_q); end
			ST_C_V_Y:   begin ma = sx(vy_q); mb = sx(vy_q); end
			ST_C_W_X:   begin ma = sx(wx_q); mb = sx(wx_q); end
			ST_C_W_Y:   begin ma = sx(wy_q); mb = sx(wy_q); end
			ST_C_CR_A, ST_R_NUM_A: begin ma = sx(dx_q); mb = sx(vy_q); end
			ST_C_CR_B, ST_R_NUM_B: begin ma = sx(dy_q); mb = sx(vx_q); end
			ST_C_SQ_HH: begin ma = {4'b0, cr_q[48:26]}; mb = {4'b0, cr_q[48:26]}; end
			ST_C_SQ_HL: begin ma = {4'b0, cr_q[48:26]}; mb = {1'b0, cr_q[25:0]}; end
			ST_C_SQ_LL: begin ma = {1'b0, cr_q[25:0]}; mb = {1'b0, cr_q[25:0]}; end
			ST_C_RL_HH: begin ma = {7'b0, cur_q.r2[45:26]}; mb = {4'b0, len2_q[48:26]}; end
			ST_C_RL_HL: begin ma = {7'b0, cur_q.r2[45:26]}; mb = {1'b0, len2_q[25:0]}; end
			ST_C_RL_LH: begin ma = {1'b0, cur_q.r2[25:0]}; mb = {4'b0, len2_q[48:26]}; end
			ST_C_RL_LL: begin ma = {1'b0, cur_q.r2[25:0]}; mb = {1'b0, len2_q[25:0]}; end
			ST_R_DEN_A: begin ma = sx(dy_q); mb = sx(cur_q.rx); end
			ST_R_DEN_B: begin ma = sx(dx_q); mb = sx(cur_q.ry); end
			ST_R_NB_A:  begin ma = sx(cur_q.rx); mb = sx(vy_q); end
			ST_R_NB_B:  begin ma = sx(cur_q.ry); mb = sx(vx_q); end
			ST_R_PX_L:  begin ma = {1'b0, num_q[25:0]}; mb = {2'b0, rxm}; end
			ST_R_PX_H:  begin ma = {4'b0, num_q[48:26]}; mb = {2'b0, rxm}; end
			ST_R_PY_L:  begin ma = {1'b0, num_q[25:0]}; mb = {2'b0, rym}; end
			ST_R_PY_H:  begin ma = {4'b0, num_q[48:26]}; mb = {2'b0, rym}; end
			ST_R_DX:    begin ma = {2'b0, qx_q}; mb = {2'b0, qx_q}; end
			ST_R_DY:    begin ma = {2'b0, qy_q}; mb = {2'b0, qy_q}; end
			default: begin
				ma = '0;
				mb = '0;
			end
		endcase
	end

	assign prod = ma * mb;
	assign pu   = prod;

	// circle decisions
	assign c_end      = (len2_q == '0) || t_q[50];
	assign c_far      = t_q[49:0] > len2_q;
	assign c_dec_hit  = c_end ? (dv_q <= 50'(cur_q.r2)) : (c_far && (dw_q <= 50'(cur_q.r2)));
	assign c_wide_hit = lhs_q <= rhs_q;

	// ray decisions after sign normalization
	assign nn   = den_q[50] ? -num_q : num_q;
	assign dd   = den_q[50] ? -den_q : den_q;
	assign bb   = den_q[50] ? -nb_q : nb_q;
	assign r_ok = (num_q != '0) && (den_q != '0) && (nb_q != '0) && !nn[50] && !(nn > dd)
		&& !bb[50] && !(bb > dd);

	// rounding divider step
	assign nx   = {px_q, 1'b0} + 77'(den_q[49:0]);
	assign ny   = {py_q, 1'b0} + 77'(den_q[49:0]);
	assign dvs  = {1'b0, den_q[49:0], 1'b0};
	assign trx  = {remx_q[50:0], nshx_q[24]};
	assign try_ = {remy_q[50:0], nshy_q[24]};
	assign gex  = trx >= dvs;
	assign gey  = try_ >= dvs;

	// hit point
	assign hx_sum = {cur_q.ax[23], cur_q.ax} + (cur_q.rx[24] ? (~qx_q + 25'd1) : qx_q);
	assign hy_sum = {cur_q.ay[23], cur_q.ay} + (cur_q.ry[24] ? (~qy_q + 25'd1) : qy_q);

	assign seg_done_ok = (CW'(idx_q + 1'b1) == n_q);

	assign q_ready   = (state_q == ST_IDLE);
	assign rsp.valid = ovalid_q;
	assign rsp.hit   = ohit_q;
	assign rsp.hit_x = ohx_q;
	assign rsp.hit_y = ohy_q;

	// write the segment store
	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && q_valid && q_data.op == OP_WRITE) begin
			mem[AW'(q_data.slot)] <= {q_data.ax, q_data.ay, q_data.bx, q_data.by};
		end
	end

	// sequence the work and hold the result
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			ovalid_q <= 1'b0;
			ohit_q   <= 1'b0;
			ohx_q    <= '0;
			ohy_q    <= '0;
		end else begin
			if (rsp.ready && state_q != ST_DONE) ovalid_q <= 1'b0;
			case (state_q)
				ST_IDLE: begin
					if (q_valid && q_data.op != OP_WRITE) begin
						state_q <= (lim == '0) ? ST_DONE : ST_RD;
					end
				end
				ST_RD:      state_q <= ST_LD;
				ST_LD:      state_q <= (cur_q.op == OP_RAY) ? ST_R_NUM_A : ST_C_LEN_X;
				ST_C_LEN_X: state_q <= ST_C_LEN_Y;
				ST_C_LEN_Y: state_q <= ST_C_T_X;
				ST_C_T_X:   state_q <= ST_C_T_Y;
				ST_C_T_Y:   state_q <= ST_C_V_X;
				ST_C_V_X:   state_q <= ST_C_V_Y;
				ST_C_V_Y:   state_q <= ST_C_W_X;
				ST_C_W_X:   state_q <= ST_C_W_Y;
				ST_C_W_Y:   state_q <= ST_C_CR_A;
				ST_C_CR_A:  state_q <= ST_C_CR_B;
				ST_C_CR_B:  state_q <= ST_C_DEC;
				ST_C_DEC: begin
					if (c_end || c_far) begin
						state_q <= c_dec_hit ? ST_DONE : ST_NEXT;
					end else begin
						state_q <= ST_C_SQ_HH;
					end
				end
				ST_C_SQ_HH: state_q <= ST_C_SQ_HL;
				ST_C_SQ_HL: state_q <= ST_C_SQ_LL;
				ST_C_SQ_LL: state_q <= ST_C_RL_HH;
				ST_C_RL_HH: state_q <= ST_C_RL_HL;
				ST_C_RL_HL: state_q <= ST_C_RL_LH;
				ST_C_RL_LH: state_q <= ST_C_RL_LL;
				ST_C_RL_LL: state_q <= ST_C_CMP;
				ST_C_CMP:   state_q <= c_wide_hit ? ST_DONE : ST_NEXT;
				ST_R_NUM_A: state_q <= ST_R_NUM_B;
				ST_R_NUM_B: state_q <= ST_R_DEN_A;
				ST_R_DEN_A: state_q <= ST_R_DEN_B;
				ST_R_DEN_B: state_q <= ST_R_NB_A;
				ST_R_NB_A:  state_q <= ST_R_NB_B;
				ST_R_NB_B:  state_q <= ST_R_DEC;
				ST_R_DEC:   state_q <= r_ok ? ST_R_PX_L : ST_NEXT;
				ST_R_PX_L:  state_q <= ST_R_PX_H;
				ST_R_PX_H:  state_q <= ST_R_PY_L;
				ST_R_PY_L:  state_q <= ST_R_PY_H;
				ST_R_PY_H:  state_q <= ST_R_DIVI;
				ST_R_DIVI:  state_q <= ST_R_DIV;
				ST_R_DIV:   state_q <= (cnt_q == '0) ? ST_R_DX : ST_R_DIV;
				ST_R_DX:    state_q <= ST_R_DY;
				ST_R_DY:    state_q <= ST_R_UPD;
				ST_R_UPD:   state_q <= ST_NEXT;
				ST_NEXT:    state_q <= seg_done_ok ? ST_DONE : ST_RD;
				ST_DONE: begin
					if (!ovalid_q || rsp.ready) begin
						ovalid_q <= 1'b1;
						ohit_q   <= hit_q;
						ohx_q    <= hx_q;
						ohy_q    <= hy_q;
						state_q  <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				if (q_valid) begin
					cur_q  <= q_data;
					idx_q  <= '0;
					n_q    <= lim;
					hit_q  <= 1'b0;
					hx_q   <= '0;
					hy_q   <= '0;
					best_q <= '0;
				end
			end
			ST_RD: seg_q <= mem[idx_q[AW-1:0]];
			ST_LD: begin
				dx_q <= diff24(seg_q.x1, seg_q.x0);
				dy_q <= diff24(seg_q.y1, seg_q.y0);
				vx_q <= diff24(cur_q.ax, seg_q.x0);
				vy_q <= diff24(cur_q.ay, seg_q.y0);
				wx_q <= diff24(cur_q.ax, seg_q.x1);
				wy_q <= diff24(cur_q.ay, seg_q.y1);
			end
			ST_C_LEN_X: len2_q <= 50'(pu);
			ST_C_LEN_Y: len2_q <= len2_q + 50'(pu);
			ST_C_T_X:   t_q <= 51'(prod);
			ST_C_T_Y:   t_q <= t_q + 51'(prod);
			ST_C_V_X:   dv_q <= 50'(pu);
			ST_C_V_Y:   dv_q <= dv_q + 50'(pu);
			ST_C_W_X:   dw_q <= 50'(pu);
			ST_C_W_Y:   dw_q <= dw_q + 50'(pu);
			ST_C_CR_A:  cr_q <= 51'(prod);
			ST_C_CR_B:  cr_q <= cr_q - 51'(prod);
			ST_C_DEC: begin
				cr_q <= cr_q[50] ? -cr_q : cr_q;
				if ((c_end || c_far) && c_dec_hit) hit_q <= 1'b1;
			end
			ST_C_SQ_HH: lhs_q <= 100'(pu) << 52;
			ST_C_SQ_HL: lhs_q <= lhs_q + (100'(pu) << 27);
			ST_C_SQ_LL: lhs_q <= lhs_q + 100'(pu);
			ST_C_RL_HH: rhs_q <= 100'(pu) << 52;
			ST_C_RL_HL: rhs_q <= rhs_q + (100'(pu) << 26);
			ST_C_RL_LH: rhs_q <= rhs_q + (100'(pu) << 26);
			ST_C_RL_LL: rhs_q <= rhs_q + 100'(pu);
			ST_C_CMP:   if (c_wide_hit) hit_q <= 1'b1;
			ST_R_NUM_A: num_q <= 51'(prod);
			ST_R_NUM_B: num_q <= num_q - 51'(prod);
			ST_R_DEN_A: den_q <= 51'(prod);
			ST_R_DEN_B: den_q <= den_q - 51'(prod);
			ST_R_NB_A:  nb_q <= 51'(prod);
			ST_R_NB_B:  nb_q <= nb_q - 51'(prod);
			ST_R_DEC: begin
				num_q <= nn;
				den_q <= dd;
			end
			ST_R_PX_L: px_q <= 76'(pu);
			ST_R_PX_H: px_q <= px_q + (76'(pu) << 26);
			ST_R_PY_L: py_q <= 76'(pu);
			ST_R_PY_H: py_q <= py_q + (76'(pu) << 26);
			ST_R_DIVI: begin
				remx_q <= 52'(nx >> 25);
				remy_q <= 52'(ny >> 25);
				nshx_q <= nx[24:0];
				nshy_q <= ny[24:0];
				qx_q   <= '0;
				qy_q   <= '0;
				cnt_q  <= 5'd24;
			end
			ST_R_DIV: begin
				remx_q <= gex ? (trx - dvs) : trx;
				remy_q <= gey ? (try_ - dvs) : try_;
				qx_q   <= {qx_q[23:0], gex};
				qy_q   <= {qy_q[23:0], gey};
				nshx_q <= nshx_q << 1;
				nshy_q <= nshy_q << 1;
				cnt_q  <= cnt_q - 5'd1;
			end
			ST_R_DX: dist_q <= 50'(pu);
			ST_R_DY: dist_q <= dist_q + 50'(pu);
			ST_R_UPD: begin
				// only a strictly nearer hit replaces the kept one
				if (!hit_q || dist_q < best_q) begin
					best_q <= dist_q;
					hx_q   <= hx_sum[23:0];
					hy_q   <= hy_sum[23:0];
				end
				hit_q <= 1'b1;
			end
			ST_NEXT: idx_q <= CW'(idx_q + 1'b1);
			default: ;
		endcase
	end

endmodule
